// File: rtl/xrr_pkg.sv
// shared types, constants and step function for the xorshift96 range generator
package xrr_pkg;

  localparam logic [31:0] SEED_A_RESET = 32'd3369674297;
  localparam logic [31:0] SEED_B_RESET = 32'd1430037335;
  localparam logic [31:0] SEED_C_RESET = 32'd3845079233;

  localparam int SHIFT_T_LEFT  = 11;
  localparam int SHIFT_C_RIGHT = 19;
  localparam int SHIFT_T_RIGHT = 8;

  localparam int WORD_W  = 32;
  localparam int VALUE_W = 64;
  localparam int KEEP_W  = 7;
  localparam int MOD_CNT_W = $clog2(VALUE_W);

  localparam logic [KEEP_W-1:0] KEEP_FULL = KEEP_W'(VALUE_W);

  localparam logic [1:0] REG_SEED_A = 2'd0;
  localparam logic [1:0] REG_SEED_B = 2'd1;
  localparam logic [1:0] REG_SEED_C = 2'd2;

  localparam logic ACTION_RAW   = 1'b0;
  localparam logic ACTION_RANGE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DRAW,
    S_EVAL,
    S_MOD,
    S_ADD,
    S_OUT
  } state_t;

  function automatic logic [WORD_W-1:0] next_c(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] c);
    logic [WORD_W-1:0] t;
    t = a ^ (a << SHIFT_T_LEFT);
    return c ^ (c >> SHIFT_C_RIGHT) ^ t ^ (t >> SHIFT_T_RIGHT);
  endfunction

endpackage

// File: rtl/xorshift96_range_rng.sv
// xorshift96 random generator with raw masked draws and range reduction
// Each transaction on the s_ side draws one or two 32-bit words (two when
// draw_words is 2 or 3, first word high) and returns one result on the m_
// side. Raw mode masks the draw to keep_bits low bits. Range mode
// returns range_low + draw mod (range_high - range_low) modulo 2^64; the
// remainder comes from a 64-bit subtract-and-compare unit that retires one
// bit per cycle. A zero span skips the remainder loop, sets span_error and
// returns zero. The block takes no new item while one is in work; a
// finished result waits in the output register while the next item is
// accepted, and results are only held back further when m_tready stays low.
// Seed writes on the cfg port reload one generator word (index 3 reloads
// none); the user must make them only while the block is idle, as the
// block itself does not enforce this.
module xorshift96_range_rng (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [143:0]  s_tdata,   // draw_words[1:0], keep_bits[8:2], range_low[72:9],
                                   // range_high[136:73], zero pad
  input  logic          s_tuser,   // action
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [63:0]   m_tdata,   // value
  output logic          m_tuser,   // span_error
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int W  = xrr_pkg::WORD_W;
  localparam int VW = xrr_pkg::VALUE_W;
  localparam int KW = xrr_pkg::KEEP_W;
  localparam int CW = xrr_pkg::MOD_CNT_W;

  xrr_pkg::state_t state, state_next;

  logic [W-1:0]  word_a, word_b, word_c;
  logic [W-1:0]  step_c;
  logic          act;
  logic          two_words;
  logic          draw_cnt;
  logic [KW-1:0] keep;
  logic [VW-1:0] lo;
  logic [VW-1:0] span;
  logic [VW-1:0] draw;
  logic [VW-1:0] rem;
  logic [VW:0]   rem_shift;
  logic [VW:0]   rem_diff;
  logic [CW-1:0] mod_cnt;
  logic [VW-1:0] res_value;
  logic          res_err;
  logic [VW-1:0] keep_mask;
  logic          in_fire;
  logic          out_load;

  assign step_c    = xrr_pkg::next_c(word_a, word_c);
  assign in_fire   = s_tvalid && s_tready;
  assign out_load  = (state == xrr_pkg::S_OUT) && (!m_tvalid || m_tready);
  assign rem_shift = {rem, draw[VW-1]};
  assign rem_diff  = rem_shift - {1'b0, span};
  assign keep_mask = (keep >= xrr_pkg::KEEP_FULL) ? {VW{1'b1}}
                                                  : ~({VW{1'b1}} << keep[CW-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= xrr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      xrr_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          state_next = xrr_pkg::S_DRAW;
        end
      end
      xrr_pkg::S_DRAW: begin
        if (!two_words || draw_cnt) begin
          state_next = xrr_pkg::S_EVAL;
        end
      end
      xrr_pkg::S_EVAL: begin
        if (act == xrr_pkg::ACTION_RANGE && span != '0) begin
          state_next = xrr_pkg::S_MOD;
        end else begin
          state_next = xrr_pkg::S_OUT;
        end
      end
      xrr_pkg::S_MOD: begin
        if (mod_cnt == '0) begin
          state_next = xrr_pkg::S_ADD;
        end
      end
      xrr_pkg::S_ADD: begin
        state_next = xrr_pkg::S_OUT;
      end
      xrr_pkg::S_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = xrr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = xrr_pkg::S_IDLE;
      end
    endcase
  end

  // generator words
  always_ff @(posedge clk) begin
    if (rst) begin
      word_a <= xrr_pkg::SEED_A_RESET;
      word_b <= xrr_pkg::SEED_B_RESET;
      word_c <= xrr_pkg::SEED_C_RESET;
    end else if (cfg_we) begin
      if (cfg_index == xrr_pkg::REG_SEED_A) word_a <= cfg_data;
      if (cfg_index == xrr_pkg::REG_SEED_B) word_b <= cfg_data;
      if (cfg_index == xrr_pkg::REG_SEED_C) word_c <= cfg_data;
    end else if (state == xrr_pkg::S_DRAW) begin
      word_a <= word_b;
      word_b <= word_c;
      word_c <= step_c;
    end
  end

  // item capture, draw assembly and remainder unit
  always_ff @(posedge clk) begin
    if (in_fire) begin
      act       <= s_tuser;
      two_words <= s_tdata[1];
      keep      <= s_tdata[8:2];
      lo        <= s_tdata[72:9];
      span      <= s_tdata[136:73] - s_tdata[72:9];
      draw      <= '0;
      draw_cnt  <= 1'b0;
    end
    unique case (state)
      xrr_pkg::S_DRAW: begin
        draw     <= {draw[W-1:0], step_c};
        draw_cnt <= 1'b1;
      end
      xrr_pkg::S_EVAL: begin
        rem     <= '0;
        mod_cnt <= CW'(VW - 1);
        res_err <= 1'b0;
        if (act == xrr_pkg::ACTION_RAW) begin
          res_value <= draw & keep_mask;
        end else if (span == '0) begin
          res_value <= '0;
          res_err   <= 1'b1;
        end
      end
      xrr_pkg::S_MOD: begin
        if (!rem_diff[VW]) begin
          rem <= rem_diff[VW-1:0];
        end else begin
          rem <= rem_shift[VW-1:0];
        end
        draw    <= {draw[VW-2:0], 1'b0};
        mod_cnt <= mod_cnt - 1'b1;
      end
      xrr_pkg::S_ADD: begin
        res_value <= lo + rem;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res_value;
      m_tuser <= res_err;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("span error result with nonzero value");

  a_rem_below_span: assert property (@(posedge clk) disable iff (rst)
    (state == xrr_pkg::S_MOD || state == xrr_pkg::S_ADD) |-> (rem < span))
    else $error("remainder not below span");

  a_accept_draws: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (state == xrr_pkg::S_DRAW))
    else $error("accepted transaction did not start a draw");

  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == xrr_pkg::S_OUT))
    else $error("result shown outside the output step");

endmodule
